@@ hw/rtl/ide_pkg.sv @@
// Shared types and constants for the immediate dominator engine.
// No dependencies; every other file imports this package.
package ide_pkg;

  localparam int NODE_W      = 8;
  localparam int DOM_W       = 9;
  localparam int POS_W       = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int MAX_NODES_DEF = 256;

  localparam logic [DOM_W-1:0] UNDEF_DOM = DOM_W'(TABLE_DEPTH);

  typedef enum logic [1:0] {
    CMD_PLACE  = 2'd0,
    CMD_MERGE  = 2'd1,
    CMD_READ   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    RES_UNDEF,
    RES_DOMRD,
    RES_CUR,
    RES_PRED,
    RES_A
  } res_src_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     latch;        // capture the accepted request
    logic     pos_wr;       // position[node] = order
    logic     dom_clr;      // mark dominator[node] undefined
    logic     dom_wr;       // write dominator[node]
    logic     wr_src_pred;  // 1: write pred_node, 0: write meeting point a
    logic     dom_rd_node;  // read dominator[node]
    logic     pos_rd_en;    // read two positions
    logic     pos_rd_walk;  // 1: addresses a/b, 0: node/pred_node
    logic     load_cur;     // capture dominator[node]
    logic     walk_init;    // a = cur, b = pred_node, steps = 0
    logic     climb_issue;  // pick climbing side, read its dominator
    logic     climb_apply;  // move climbing side up, count step
    logic     res_set;      // load result register
    res_src_e res_src;
    logic     res_err;
    logic     out_load;     // move result into output register
  } ide_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    cmd_e cmd;
    logic node_oor;
    logic pred_oor;
    logic order_bad;
    logic cur_undef;
    logic ab_eq;
    logic ab_oor;
    logic a_oor;
    logic steps_done;
    logic out_free;
  } ide_sts_t;

endpackage

@@ hw/rtl/ide_if.sv @@
// Request and response stream interfaces of the immediate dominator engine.
// Depends on ide_pkg for field widths.
interface ide_req_if;
  import ide_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [NODE_W-1:0] node;
  logic [NODE_W-1:0] pred_node;
  logic [POS_W-1:0]  order;

  modport source (output valid, cmd, node, pred_node, order, input ready);
  modport sink   (input valid, cmd, node, pred_node, order, output ready);
endinterface

interface ide_rsp_if;
  import ide_pkg::*;
  logic             valid;
  logic             ready;
  logic [DOM_W-1:0] dom_node;
  logic             error;

  modport source (output valid, dom_node, error, input ready);
  modport sink   (input valid, dom_node, error, output ready);
endinterface

@@ hw/rtl/ide_datapath.sv @@
// Datapath: request registers, position and dominator tables, walk registers,
// result and output registers. Depends on ide_pkg.
module ide_datapath #(
  parameter int MAX_NODES = ide_pkg::MAX_NODES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ide_pkg::ide_ctl_t         ctl_i,
  output ide_pkg::ide_sts_t         sts_o,
  input  logic [1:0]                cmd_i,
  input  logic [ide_pkg::NODE_W-1:0] node_i,
  input  logic [ide_pkg::NODE_W-1:0] pred_i,
  input  logic [ide_pkg::POS_W-1:0]  order_i,
  input  logic                      out_ready_i,
  output logic                      out_valid_o,
  output logic [ide_pkg::DOM_W-1:0] out_dom_o,
  output logic                      out_err_o
);
  import ide_pkg::*;

  localparam int STEP_W = $clog2(MAX_NODES + 1);
  localparam int ADDR_W = $clog2(TABLE_DEPTH);

  logic [1:0]        cmd_q;
  logic [NODE_W-1:0] node_q, pred_q;
  logic [POS_W-1:0]  order_q;

  logic [POS_W-1:0]  pos_mem [TABLE_DEPTH];
  logic [POS_W-1:0]  pos_a_q, pos_b_q;
  logic [ADDR_W-1:0] pos_addr_a, pos_addr_b;

  logic [DOM_W-1:0]  dom_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] dom_vld_q;
  logic [DOM_W-1:0]  dom_dat_q;
  logic              dom_vbit_q;
  logic [DOM_W-1:0]  dom_rd;
  logic [ADDR_W-1:0] dom_rd_addr;
  logic [DOM_W-1:0]  dom_wr_val;

  logic [DOM_W-1:0]  cur_q, a_q, b_q;
  logic [STEP_W-1:0] steps_q;
  logic              side_b_q;

  logic [DOM_W-1:0]  res_dom_q;
  logic              res_err_q;
  logic [DOM_W-1:0]  out_dom_q;
  logic              out_err_q;
  logic              out_valid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= cmd_i;
      node_q  <= node_i;
      pred_q  <= pred_i;
      order_q <= order_i;
    end
  end

  // Position table: one write port, two registered read ports
  assign pos_addr_a = ctl_i.pos_rd_walk ? a_q[ADDR_W-1:0] : ADDR_W'(node_q);
  assign pos_addr_b = ctl_i.pos_rd_walk ? b_q[ADDR_W-1:0] : ADDR_W'(pred_q);

  always_ff @(posedge clk_i) begin
    if (ctl_i.pos_wr) begin
      pos_mem[ADDR_W'(node_q)] <= order_q;
    end
    if (ctl_i.pos_rd_en) begin
      pos_a_q <= pos_mem[pos_addr_a];
      pos_b_q <= pos_mem[pos_addr_b];
    end
  end

  // Dominator table: data array plus per-entry valid bits cleared by reset
  assign dom_rd_addr = ctl_i.climb_issue
                     ? ((pos_a_q < pos_b_q) ? b_q[ADDR_W-1:0] : a_q[ADDR_W-1:0])
                     : ADDR_W'(node_q);
  assign dom_wr_val  = ctl_i.wr_src_pred ? DOM_W'(pred_q) : a_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.dom_wr) begin
      dom_mem[ADDR_W'(node_q)] <= dom_wr_val;
    end
    if (ctl_i.dom_rd_node || ctl_i.climb_issue) begin
      dom_dat_q <= dom_mem[dom_rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_vld_q  <= '0;
      dom_vbit_q <= 1'b0;
    end else begin
      if (ctl_i.dom_wr) begin
        dom_vld_q[ADDR_W'(node_q)] <= 1'b1;
      end else if (ctl_i.dom_clr) begin
        dom_vld_q[ADDR_W'(node_q)] <= 1'b0;
      end
      if (ctl_i.dom_rd_node || ctl_i.climb_issue) begin
        dom_vbit_q <= dom_vld_q[dom_rd_addr];
      end
    end
  end

  assign dom_rd = dom_vbit_q ? dom_dat_q : UNDEF_DOM;

  // Walk registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.load_cur) begin
      cur_q <= dom_rd;
    end
    if (ctl_i.walk_init) begin
      a_q     <= dom_rd;
      b_q     <= DOM_W'(pred_q);
      steps_q <= '0;
    end else if (ctl_i.climb_apply) begin
      if (side_b_q) begin
        b_q <= dom_rd;
      end else begin
        a_q <= dom_rd;
      end
      steps_q <= steps_q + STEP_W'(1);
    end
    if (ctl_i.climb_issue) begin
      side_b_q <= (pos_a_q < pos_b_q);
    end
  end

  // Result and output registers
  always_ff @(posedge clk_i) begin
    if (ctl_i.res_set) begin
      res_err_q <= ctl_i.res_err;
      case (ctl_i.res_src)
        RES_UNDEF: res_dom_q <= UNDEF_DOM;
        RES_DOMRD: res_dom_q <= dom_rd;
        RES_CUR:   res_dom_q <= cur_q;
        RES_PRED:  res_dom_q <= DOM_W'(pred_q);
        RES_A:     res_dom_q <= a_q;
        default:   res_dom_q <= UNDEF_DOM;
      endcase
    end
    if (ctl_i.out_load) begin
      out_dom_q <= res_dom_q;
      out_err_q <= res_err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dom_o   = out_dom_q;
  assign out_err_o   = out_err_q;

  always_comb begin
    sts_o.cmd        = cmd_e'(cmd_q);
    sts_o.node_oor   = int'(node_q) >= MAX_NODES;
    sts_o.pred_oor   = int'(pred_q) >= MAX_NODES;
    sts_o.order_bad  = pos_b_q >= pos_a_q;
    sts_o.cur_undef  = dom_rd == UNDEF_DOM;
    sts_o.ab_eq      = a_q == b_q;
    sts_o.ab_oor     = (a_q >= UNDEF_DOM) || (b_q >= UNDEF_DOM);
    sts_o.a_oor      = a_q >= UNDEF_DOM;
    sts_o.steps_done = 32'(steps_q) >= MAX_NODES;
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

@@ hw/rtl/ide_ctrl.sv @@
// Controller: sequences decode, table access, the dominator walk and the
// response. Depends on ide_pkg.
module ide_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  output logic               req_ready_o,
  input  ide_pkg::ide_sts_t  sts_i,
  output ide_pkg::ide_ctl_t  ctl_o
);
  import ide_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_READ,
    S_MCHK,
    S_WCMP,
    S_WPOS,
    S_WDOM,
    S_RESP
  } state_e;

  state_e state_q;
  logic   ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            state_q <= S_DECODE;
            ready_q <= 1'b0;
          end
        end
        S_DECODE: begin
          if (sts_i.node_oor || sts_i.cmd == CMD_PLACE) begin
            state_q <= S_RESP;
          end else if (sts_i.cmd == CMD_MERGE) begin
            state_q <= S_MCHK;
          end else begin
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_RESP;
        S_MCHK: begin
          if (sts_i.pred_oor || sts_i.order_bad || sts_i.cur_undef) begin
            state_q <= S_RESP;
          end else begin
            state_q <= S_WCMP;
          end
        end
        S_WCMP: begin
          if (sts_i.ab_eq || sts_i.ab_oor || sts_i.steps_done) begin
            state_q <= S_RESP;
          end else begin
            state_q <= S_WPOS;
          end
        end
        S_WPOS: state_q <= S_WDOM;
        S_WDOM: state_q <= S_WCMP;
        S_RESP: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign req_ready_o = ready_q;

  always_comb begin
    ctl_o = '0;
    ctl_o.res_src = RES_UNDEF;
    case (state_q)
      S_IDLE: ctl_o.latch = req_valid_i;
      S_DECODE: begin
        if (sts_i.node_oor) begin
          ctl_o.res_set = 1'b1;
          ctl_o.res_err = 1'b1;
        end else begin
          case (sts_i.cmd)
            CMD_PLACE: begin
              ctl_o.pos_wr  = 1'b1;
              ctl_o.dom_clr = 1'b1;
              ctl_o.res_set = 1'b1;
            end
            CMD_MERGE: begin
              ctl_o.dom_rd_node = 1'b1;
              ctl_o.pos_rd_en   = 1'b1;
            end
            default: ctl_o.dom_rd_node = 1'b1;
          endcase
        end
      end
      S_READ: begin
        ctl_o.res_set = 1'b1;
        ctl_o.res_src = RES_DOMRD;
        ctl_o.res_err = sts_i.cmd == CMD_UNUSED;
      end
      S_MCHK: begin
        ctl_o.load_cur = 1'b1;
        if (sts_i.pred_oor || sts_i.order_bad) begin
          ctl_o.res_set = 1'b1;
          ctl_o.res_src = RES_DOMRD;
          ctl_o.res_err = 1'b1;
        end else if (sts_i.cur_undef) begin
          ctl_o.dom_wr      = 1'b1;
          ctl_o.wr_src_pred = 1'b1;
          ctl_o.res_set     = 1'b1;
          ctl_o.res_src     = RES_PRED;
        end else begin
          ctl_o.walk_init = 1'b1;
        end
      end
      S_WCMP: begin
        if (sts_i.ab_eq && !sts_i.a_oor) begin
          ctl_o.dom_wr  = 1'b1;
          ctl_o.res_set = 1'b1;
          ctl_o.res_src = RES_A;
        end else if (sts_i.ab_eq || sts_i.ab_oor || sts_i.steps_done) begin
          ctl_o.res_set = 1'b1;
          ctl_o.res_src = RES_CUR;
          ctl_o.res_err = 1'b1;
        end else begin
          ctl_o.pos_rd_en   = 1'b1;
          ctl_o.pos_rd_walk = 1'b1;
        end
      end
      S_WPOS: ctl_o.climb_issue = 1'b1;
      S_WDOM: ctl_o.climb_apply = 1'b1;
      S_RESP: ctl_o.out_load = sts_i.out_free;
      default: ctl_o = '0;
    endcase
  end

endmodule

@@ hw/rtl/immediate_dominator_engine.sv @@
// Immediate dominator engine top level: controller plus datapath.
// Depends on ide_pkg, ide_if, ide_ctrl and ide_datapath.
//
//   channel  direction  carries                         handshake
//   req_i    in         cmd, node, pred_node, order     valid / ready
//   rsp_o    out        dom_node, error                 valid / ready
//
// One request at a time. Place: decode, then response; read: decode, table read,
// response; merge that ends at its order or undefined check: decode, check,
// response; merge with a walk: decode, check, then climbs until it meets or fails;
// each climb costs a position table read, a compare and a dominator table read.
// Reset clears the dominator valid bits at once, so every entry reads as
// undefined; no clearing pass is needed.
// The output register holds a response while rsp_o stalls; the next request
// is accepted meanwhile and waits only at its own response step.
module immediate_dominator_engine #(
  parameter int MAX_NODES = ide_pkg::MAX_NODES_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ide_req_if.sink   req_i,
  ide_rsp_if.source rsp_o
);
  import ide_pkg::*;

  ide_ctl_t ctl;
  ide_sts_t sts;

  // Sequence each request through decode, table access and walk
  ide_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  // Hold tables, walk pointers and the response register
  ide_datapath #(
    .MAX_NODES (MAX_NODES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .cmd_i       (req_i.cmd),
    .node_i      (req_i.node),
    .pred_i      (req_i.pred_node),
    .order_i     (req_i.order),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_dom_o   (rsp_o.dom_node),
    .out_err_o   (rsp_o.error)
  );

`ifndef SYNTH
  // Never overwrite a response that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> sts.out_free)
    else $error("response register overwritten");

  // An accepted request makes the block busy on the next cycle
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while busy");

  // Climb only when the walk has neither met nor failed
  a_climb_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.climb_issue |-> (!sts.ab_eq && !sts.ab_oor && !sts.steps_done))
    else $error("climb issued on finished walk");

  // Start a walk only from a defined dominator and an ordered arc
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.walk_init |-> (!sts.cur_undef && !sts.order_bad && !sts.pred_oor))
    else $error("walk started on invalid merge");
`endif

endmodule

@@ sim/ide_dom_checker.sv @@
// Request/response checker for the immediate dominator engine.
// Depends on ide_pkg and the ide_req_if / ide_rsp_if interfaces.
// Watches both channels, keeps its own dominator and position tables, and counts mismatches.
module ide_dom_checker #(
  parameter int MAX_NODES = ide_pkg::MAX_NODES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  ide_req_if   req_i,
  ide_rsp_if   rsp_i,
  output int   mismatch_cnt_o,
  output int   pending_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import ide_pkg::*;

  typedef struct packed {
    logic [DOM_W-1:0] dom_node;
    logic             error;
  } dom_rsp_t;

  logic [DOM_W-1:0] dom_tbl [TABLE_DEPTH];
  logic [POS_W-1:0] pos_tbl [TABLE_DEPTH];
  dom_rsp_t         dom_expect_q [$];
  dom_rsp_t         want_rsp;

  // Apply one request to the shadow tables and return the response it must produce.
  function automatic dom_rsp_t resolve_request(cmd_e cmd, logic [NODE_W-1:0] node,
                                               logic [NODE_W-1:0] pred,
                                               logic [POS_W-1:0] ord);
    dom_rsp_t         res;
    logic [DOM_W-1:0] a;
    logic [DOM_W-1:0] b;
    int               climbs;
    logic             stuck;
    res.error = 1'b0;
    if (int'(node) >= MAX_NODES) begin
      res.dom_node = UNDEF_DOM;
      res.error    = 1'b1;
      return res;
    end
    case (cmd)
      CMD_PLACE: begin
        pos_tbl[node] = ord;
        dom_tbl[node] = UNDEF_DOM;
      end
      CMD_MERGE: begin
        if (int'(pred) >= MAX_NODES || pos_tbl[pred] >= pos_tbl[node]) begin
          res.error = 1'b1;
        end else if (dom_tbl[node] == UNDEF_DOM) begin
          dom_tbl[node] = {1'b0, pred};
        end else begin
          // Climb the side with the later position until both sides meet.
          a      = dom_tbl[node];
          b      = {1'b0, pred};
          climbs = 0;
          stuck  = 1'b0;
          while (a != b && !stuck) begin
            if (a >= UNDEF_DOM || b >= UNDEF_DOM || climbs >= MAX_NODES) begin
              stuck = 1'b1;
            end else begin
              if (pos_tbl[a[NODE_W-1:0]] < pos_tbl[b[NODE_W-1:0]]) begin
                b = dom_tbl[b[NODE_W-1:0]];
              end else begin
                a = dom_tbl[a[NODE_W-1:0]];
              end
              climbs++;
            end
          end
          if (stuck || a >= UNDEF_DOM) begin
            res.error = 1'b1;
          end else begin
            dom_tbl[node] = a;
          end
        end
      end
      CMD_UNUSED: res.error = 1'b1;
      default: ;
    endcase
    res.dom_node = dom_tbl[node];
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        dom_tbl[i] = UNDEF_DOM;
        pos_tbl[i] = '0;
      end
      dom_expect_q.delete();
      pending_cnt_o  = 0;
      mismatch_cnt_o = 0;
    end else begin
      if (rsp_i.valid === 1'b1 && rsp_i.ready === 1'b1) begin
        if (dom_expect_q.size() == 0) begin
          $error("unexpected response: dom_node %0d error %0b", rsp_i.dom_node, rsp_i.error);
          mismatch_cnt_o++;
        end else begin
          want_rsp = dom_expect_q.pop_front();
          if (rsp_i.dom_node !== want_rsp.dom_node) begin
            $error("dom_node: expected %0d, actual %0d", want_rsp.dom_node, rsp_i.dom_node);
            mismatch_cnt_o++;
          end
          if (rsp_i.error !== want_rsp.error) begin
            $error("error: expected %0b, actual %0b", want_rsp.error, rsp_i.error);
            mismatch_cnt_o++;
          end
        end
      end
      if (req_i.valid === 1'b1 && req_i.ready === 1'b1) begin
        dom_expect_q.push_back(resolve_request(cmd_e'(req_i.cmd), req_i.node,
                                               req_i.pred_node, req_i.order));
      end
      pending_cnt_o = dom_expect_q.size();
    end
  end

endmodule

@@ sim/tb_immediate_dominator_engine.sv @@
// Top-level testbench for the immediate dominator engine: clock, reset, stimulus and verdict.
// Depends on ide_pkg, the ide_req_if / ide_rsp_if interfaces, the engine and ide_dom_checker.
module tb_immediate_dominator_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import ide_pkg::*;

  // Worst case per request is a merge that climbs to the walk bound,
  // plus sender gaps and receiver stalls; the cap leaves several times
  // that margin over all requests.
  localparam int CYCLE_LIMIT  = 5_000_000;
  localparam int RANDOM_ITEMS = 400;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i;
  logic rst_ni;
  int   mismatch_cnt;
  int   pending_cnt;
  int   cycle_cnt;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   req_sent;

  // Nodes whose position has been written: a merge may only name these,
  // so the engine never reads a position entry that was never written.
  bit                placed [TABLE_DEPTH];
  logic [NODE_W-1:0] placed_ids [$];

  ide_req_if req_bus ();
  ide_rsp_if rsp_bus ();

  immediate_dominator_engine #(
    .MAX_NODES(MAX_NODES_DEF)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  ide_dom_checker #(
    .MAX_NODES(MAX_NODES_DEF)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_bus),
    .rsp_i         (rsp_bus),
    .mismatch_cnt_o(mismatch_cnt),
    .pending_cnt_o (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop if the engine hangs or the run drags on.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Response back-pressure: drop ready at random, per the current idle rate.
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [NODE_W-1:0] pick_placed();
    return placed_ids[$urandom_range(placed_ids.size() - 1)];
  endfunction

  // Present one request at a falling edge, hold it until accepted, and return
  // at the next falling edge. Valid is only dropped when the sender idles, so
  // back-to-back requests keep it high without a glitch.
  task automatic send_request(cmd_e cmd, logic [NODE_W-1:0] node,
                              logic [NODE_W-1:0] pred, logic [POS_W-1:0] ord);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_bus.valid     <= 1'b1;
    req_bus.cmd       <= cmd;
    req_bus.node      <= node;
    req_bus.pred_node <= pred;
    req_bus.order     <= ord;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    @(negedge clk_i);
    if (cmd == CMD_PLACE && !placed[node]) begin
      placed[node] = 1'b1;
      placed_ids.push_back(node);
    end
    req_sent++;
  endtask

  // Field extremes, every command and each corner of the merge walk.
  task automatic run_directed();
    // Read of a node never placed, and the unused command.
    send_request(CMD_READ, 8'd0, any_byte(), any_byte());
    send_request(CMD_UNUSED, 8'd255, any_byte(), any_byte());
    // Chain 0 -> 1 -> 128 -> 255 with extreme positions.
    send_request(CMD_PLACE, 8'd0, any_byte(), 8'd0);
    send_request(CMD_PLACE, 8'd255, any_byte(), 8'd255);
    send_request(CMD_PLACE, 8'd128, any_byte(), 8'd128);
    send_request(CMD_PLACE, 8'd1, any_byte(), 8'd1);
    // Merges into undefined dominators take the predecessor directly.
    send_request(CMD_MERGE, 8'd1, 8'd0, any_byte());
    send_request(CMD_MERGE, 8'd128, 8'd1, any_byte());
    send_request(CMD_MERGE, 8'd255, 8'd128, any_byte());
    // Walks that climb and meet at node 0, from either side.
    send_request(CMD_MERGE, 8'd255, 8'd0, any_byte());
    send_request(CMD_MERGE, 8'd255, 8'd1, any_byte());
    // Arcs out of order: a later predecessor, and a node onto itself.
    send_request(CMD_MERGE, 8'd0, 8'd255, any_byte());
    send_request(CMD_MERGE, 8'd128, 8'd128, any_byte());
    send_request(CMD_READ, 8'd255, any_byte(), any_byte());
    // Walk that climbs into an undefined entry.
    send_request(CMD_PLACE, 8'd40, any_byte(), 8'd0);
    send_request(CMD_PLACE, 8'd60, any_byte(), 8'd1);
    send_request(CMD_PLACE, 8'd70, any_byte(), 8'd2);
    send_request(CMD_MERGE, 8'd70, 8'd60, any_byte());
    send_request(CMD_MERGE, 8'd70, 8'd40, any_byte());
    // Re-place a node to build a dominator cycle 10 <-> 20, then walk into it
    // against a lower predecessor so the climb runs into the step bound.
    send_request(CMD_PLACE, 8'd10, any_byte(), 8'd1);
    send_request(CMD_PLACE, 8'd20, any_byte(), 8'd2);
    send_request(CMD_PLACE, 8'd30, any_byte(), 8'd5);
    send_request(CMD_MERGE, 8'd20, 8'd10, any_byte());
    send_request(CMD_PLACE, 8'd10, any_byte(), 8'd3);
    send_request(CMD_MERGE, 8'd10, 8'd20, any_byte());
    send_request(CMD_MERGE, 8'd30, 8'd10, any_byte());
    send_request(CMD_MERGE, 8'd30, 8'd40, any_byte());
  endtask

  // Stray requests: random places, reads, unused commands and merges between
  // any two placed nodes, which may break chains or form cycles.
  task automatic send_noise();
    case ($urandom_range(3))
      0:       send_request(CMD_PLACE, any_byte(), any_byte(), any_byte());
      1:       send_request(CMD_READ, any_byte(), any_byte(), any_byte());
      2:       send_request(CMD_UNUSED, any_byte(), any_byte(), any_byte());
      default: send_request(CMD_MERGE, pick_placed(), pick_placed(), any_byte());
    endcase
  endtask

  // One flow graph: place a handful of distinct nodes with increasing
  // positions, then feed arcs in processing order, mostly from earlier
  // nodes so the walks run deep, with a few backward arcs and stray requests.
  task automatic run_graph();
    logic [NODE_W-1:0] ids [12];
    bit                taken [TABLE_DEPTH];
    int                n;
    int                gap;
    int                ord;
    int                j;
    n   = $urandom_range(3, 12);
    gap = 255 / n;
    for (int i = 0; i < n; i++) begin
      do ids[i] = any_byte(); while (taken[ids[i]]);
      taken[ids[i]] = 1'b1;
    end
    ord = $urandom_range(gap - 1);
    for (int i = 0; i < n; i++) begin
      send_request(CMD_PLACE, ids[i], any_byte(), 8'(ord));
      ord += $urandom_range(1, gap);
    end
    for (int i = 1; i < n; i++) begin
      repeat ($urandom_range(1, 3)) begin
        j = ($urandom_range(99) < 8) ? $urandom_range(n - 1) : $urandom_range(i - 1);
        send_request(CMD_MERGE, ids[i], ids[j], any_byte());
        if ($urandom_range(99) < 8) begin
          send_noise();
        end else if ($urandom_range(99) < 12) begin
          send_request(CMD_READ, ids[$urandom_range(n - 1)], any_byte(), any_byte());
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1) == 1) begin
        send_request(CMD_READ, ids[i], any_byte(), any_byte());
      end
    end
  endtask

  task automatic run_random(int quota);
    int stop_at;
    stop_at = req_sent + quota;
    while (req_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        send_noise();
      end else begin
        run_graph();
      end
    end
  endtask

  initial begin
    // Hold every input at a known value through reset.
    req_bus.valid     = 1'b0;
    req_bus.cmd       = CMD_READ;
    req_bus.node      = '0;
    req_bus.pred_node = '0;
    req_bus.order     = '0;
    rst_ni            = 1'b0;
    req_sent          = 0;
    snd_idle_pct      = 13;
    rcv_idle_pct      = 81;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Slow receiver first, then slow sender, then full rate both ways.
    run_directed();
    run_random(RANDOM_ITEMS / 3);
    snd_idle_pct = 81;
    rcv_idle_pct = 13;
    run_random(RANDOM_ITEMS / 3);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    req_bus.valid <= 1'b0;

    // Drain outstanding responses, then watch a little longer for strays.
    while (pending_cnt != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ide_pkg.sv
hw/rtl/ide_if.sv
hw/rtl/ide_datapath.sv
hw/rtl/ide_ctrl.sv
hw/rtl/immediate_dominator_engine.sv
sim/ide_dom_checker.sv
sim/tb_immediate_dominator_engine.sv
